// ----- hdl/pdd_pkg.sv -----
// ============================================================================
// pdd_pkg: shared types and constants for the PID differential drive
// Field widths, register codes, reset values and the structs that carry
// configuration and per-sample PID terms between the front and back parts.
// ============================================================================
package pdd_pkg;

  // Field widths
  localparam int GAIN_W     = 24;
  localparam int SPEED_W    = 8;
  localparam int POS_W      = 13;
  localparam int LIMIT_W    = 16;
  localparam int ERR_W      = POS_W + 1;
  localparam int INT_W      = 18;
  localparam int DER_W      = ERR_W + 1;
  localparam int IDX_W      = 3;
  localparam int CFG_DATA_W = GAIN_W;

  // Defaults for top-level parameters
  localparam int FRAC_BITS_DFLT   = 16;
  localparam int QUEUE_DEPTH_DFLT = 2;

  // Register reset values
  localparam logic [GAIN_W-1:0]  KP_RESET     = GAIN_W'(4260);
  localparam logic [GAIN_W-1:0]  KI_RESET     = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]  KD_RESET     = GAIN_W'(4915);
  localparam logic [SPEED_W-1:0] BASE_RESET   = SPEED_W'(50);
  localparam logic [SPEED_W-1:0] MAX_RESET    = SPEED_W'(80);
  localparam logic [POS_W-1:0]   TARGET_RESET = POS_W'(3500);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(3000);

  // Register index codes
  typedef enum logic [IDX_W-1:0] {
    REG_KP_GAIN         = 3'd0,
    REG_KI_GAIN         = 3'd1,
    REG_KD_GAIN         = 3'd2,
    REG_BASE_SPEED      = 3'd3,
    REG_MAX_SPEED       = 3'd4,
    REG_TARGET_POSITION = 3'd5,
    REG_INTEGRAL_LIMIT  = 3'd6
  } cfg_reg_t;

  // Live configuration
  typedef struct packed {
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] max_speed;
    logic [POS_W-1:0]   target_position;
    logic [LIMIT_W-1:0] integral_limit;
  } pdd_cfg_t;

  // PID terms of one sample, front to back
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [INT_W-1:0] integ;
    logic signed [DER_W-1:0] deriv;
  } pdd_terms_t;

  // One motor command
  typedef struct packed {
    logic               fwd;
    logic [SPEED_W-1:0] duty;
  } pdd_motor_t;

endpackage

// ----- hdl/pdd_front.sv -----
// ============================================================================
// pdd_front: sample intake and PID state
// Forms the error, the clamped integral and the derivative for each accepted
// sample, updates the state and pushes the terms into the queue.
// ============================================================================
module pdd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pdd_pkg::pdd_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pdd_pkg::POS_W-1:0]   in_line_position,
  input  logic                        q_full,
  output logic                        q_push,
  output pdd_pkg::pdd_terms_t         q_push_data
);
  import pdd_pkg::*;

  logic signed [ERR_W-1:0] prev_err_r, prev_err_nxt;
  logic signed [INT_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0] err;
  logic signed [INT_W:0]   integ_sum;
  logic signed [INT_W:0]   lim;
  logic signed [DER_W-1:0] deriv;

  // Back-pressure only from a full queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Error, clamped integral, derivative
  always_comb begin
    err       = $signed({1'b0, cfg.target_position}) - $signed({1'b0, in_line_position});
    integ_sum = (INT_W+1)'(integ_r) + (INT_W+1)'(err);
    lim       = $signed((INT_W+1)'(cfg.integral_limit));
    if (integ_sum > lim) begin
      integ_nxt = INT_W'(lim);
    end else if (integ_sum < -lim) begin
      integ_nxt = INT_W'(-lim);
    end else begin
      integ_nxt = INT_W'(integ_sum);
    end
    deriv        = DER_W'(err) - DER_W'(prev_err_r);
    prev_err_nxt = err;
  end

  assign q_push_data = '{err: err, integ: integ_nxt, deriv: deriv};

  // State update per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
    end else if (q_push) begin
      prev_err_r <= prev_err_nxt;
      integ_r    <= integ_nxt;
    end
  end

endmodule

// ----- hdl/pdd_queue.sv -----
// ============================================================================
// pdd_queue: short term queue between front and back
// Register-based FIFO of PID terms; lets either side stall on its own.
// ============================================================================
module pdd_queue #(
  parameter int DEPTH = pdd_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pdd_pkg::pdd_terms_t push_data,
  output logic                full,
  output logic                pop_valid,
  input  logic                pop_take,
  output pdd_pkg::pdd_terms_t pop_data
);
  import pdd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pdd_terms_t         mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_take;
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/pdd_back.sv -----
// ============================================================================
// pdd_back: drive computation and motor command pipeline
// Stage 1 multiplies the terms by the gains, stage 2 sums the drive,
// stage 3 forms base plus and minus drive, stage 4 truncates, saturates and
// splits each command into direction and duty in the output register.
// ============================================================================
module pdd_back #(
  parameter int FRAC_BITS = pdd_pkg::FRAC_BITS_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pdd_pkg::pdd_cfg_t           cfg,
  input  logic                        q_valid,
  output logic                        q_take,
  input  pdd_pkg::pdd_terms_t         q_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_left_forward,
  output logic [pdd_pkg::SPEED_W-1:0] out_left_duty,
  output logic                        out_right_forward,
  output logic [pdd_pkg::SPEED_W-1:0] out_right_duty
);
  import pdd_pkg::*;

  localparam int KP_PW = GAIN_W + 1 + ERR_W;
  localparam int KI_PW = GAIN_W + 1 + INT_W;
  localparam int KD_PW = GAIN_W + 1 + DER_W;
  localparam int DRV_W = KI_PW + 2;
  localparam int BASE_W = SPEED_W + FRAC_BITS + 1;
  localparam int MOT_W = ((BASE_W > DRV_W) ? BASE_W : DRV_W) + 1;

  // Stage valids and handshake chain
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  // Stage payloads
  logic signed [KP_PW-1:0] s1_pkp_r;
  logic signed [KI_PW-1:0] s1_pki_r;
  logic signed [KD_PW-1:0] s1_pkd_r;
  logic signed [DRV_W-1:0] s2_drive_r;
  logic signed [MOT_W-1:0] s3_left_r, s3_right_r;
  pdd_motor_t              out_left_r, out_right_r;

  logic signed [MOT_W-1:0] base_fx;
  pdd_motor_t              left_nxt, right_nxt;

  // Truncate toward zero, saturate, split into direction and duty
  function automatic pdd_motor_t motor_out(input logic signed [MOT_W-1:0] v,
                                           input logic [SPEED_W-1:0] bound);
    logic               neg;
    logic [MOT_W-1:0]   mag;
    logic [MOT_W-1:0]   whole;
    logic [SPEED_W-1:0] sat;
    pdd_motor_t         m;
    neg   = v[MOT_W-1];
    mag   = neg ? MOT_W'(-v) : MOT_W'(v);
    whole = mag >> FRAC_BITS;
    sat   = (whole > MOT_W'(bound)) ? bound : whole[SPEED_W-1:0];
    m.fwd  = !(neg && (sat != '0));
    m.duty = sat;
    return m;
  endfunction

  assign out_rdy = !out_v_r || !out_stall;
  assign s3_rdy  = !s3_v_r || out_rdy;
  assign s2_rdy  = !s2_v_r || s3_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign q_take  = s1_rdy;

  always_comb begin
    base_fx   = $signed(MOT_W'(cfg.base_speed) << FRAC_BITS);
    left_nxt  = motor_out(s3_left_r, cfg.max_speed);
    right_nxt = motor_out(s3_right_r, cfg.max_speed);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_r  <= q_valid;
      if (s2_rdy)  s2_v_r  <= s1_v_r;
      if (s3_rdy)  s3_v_r  <= s2_v_r;
      if (out_rdy) out_v_r <= s3_v_r;
    end
  end

  // Stage 1: gain products
  always_ff @(posedge clk) begin
    if (s1_rdy && q_valid) begin
      s1_pkp_r <= KP_PW'($signed({1'b0, cfg.kp_gain})) * KP_PW'(q_data.err);
      s1_pki_r <= KI_PW'($signed({1'b0, cfg.ki_gain})) * KI_PW'(q_data.integ);
      s1_pkd_r <= KD_PW'($signed({1'b0, cfg.kd_gain})) * KD_PW'(q_data.deriv);
    end
  end

  // Stage 2: drive sum
  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_drive_r <= DRV_W'(s1_pkp_r) + DRV_W'(s1_pki_r) + DRV_W'(s1_pkd_r);
    end
  end

  // Stage 3: differential motor sums
  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_left_r  <= base_fx + MOT_W'(s2_drive_r);
      s3_right_r <= base_fx - MOT_W'(s2_drive_r);
    end
  end

  // Stage 4: output register
  always_ff @(posedge clk) begin
    if (out_rdy && s3_v_r) begin
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_left_forward  = out_left_r.fwd;
  assign out_left_duty     = out_left_r.duty;
  assign out_right_forward = out_right_r.fwd;
  assign out_right_duty    = out_right_r.duty;

endmodule

// ----- hdl/pid_differential_drive.sv -----
// ============================================================================
// pid_differential_drive: PID line-follower steering block
// Turns line-position samples into left and right motor direction and duty.
//
//   channel  direction  handshake        payload
//   in_      input      valid / stall    line_position
//   out_     output     valid / stall    left/right forward, left/right duty
//   cfg_     input      valid / ready    index, data (always ready)
//
// One sample per cycle sustained while the output is not stalled; the PID
// state updates in the front in the cycle of the transfer. Results pass the
// queue, then the multiply, sum, differential and saturate stages.
// Synchronous active-low reset clears the PID state, the queue and all
// valids, and loads the register defaults. Output stall holds the pipeline;
// the input stalls only once the queue (two entries by default) has filled.
// ============================================================================
module pid_differential_drive #(
  parameter int FRAC_BITS   = pdd_pkg::FRAC_BITS_DFLT,
  parameter int QUEUE_DEPTH = pdd_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pdd_pkg::POS_W-1:0]      in_line_position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_left_forward,
  output logic [pdd_pkg::SPEED_W-1:0]    out_left_duty,
  output logic                           out_right_forward,
  output logic [pdd_pkg::SPEED_W-1:0]    out_right_duty,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pdd_pkg::IDX_W-1:0]      cfg_index,
  input  logic [pdd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pdd_pkg::*;

  pdd_cfg_t   cfg_r, cfg_nxt;
  logic       q_push, q_full, q_valid, q_take;
  pdd_terms_t q_push_data, q_data;

  // Register writes; unknown index is ignored
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KP_GAIN:         cfg_nxt.kp_gain         = cfg_data[GAIN_W-1:0];
        REG_KI_GAIN:         cfg_nxt.ki_gain         = cfg_data[GAIN_W-1:0];
        REG_KD_GAIN:         cfg_nxt.kd_gain         = cfg_data[GAIN_W-1:0];
        REG_BASE_SPEED:      cfg_nxt.base_speed      = cfg_data[SPEED_W-1:0];
        REG_MAX_SPEED:       cfg_nxt.max_speed       = cfg_data[SPEED_W-1:0];
        REG_TARGET_POSITION: cfg_nxt.target_position = cfg_data[POS_W-1:0];
        REG_INTEGRAL_LIMIT:  cfg_nxt.integral_limit  = cfg_data[LIMIT_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{kp_gain: KP_RESET, ki_gain: KI_RESET, kd_gain: KD_RESET,
                 base_speed: BASE_RESET, max_speed: MAX_RESET,
                 target_position: TARGET_RESET, integral_limit: LIMIT_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: intake and PID state
  pdd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_line_position (in_line_position),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_push_data      (q_push_data)
  );

  // Queue between front and back
  pdd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_take  (q_take),
    .pop_data  (q_data)
  );

  // Back: drive and motor commands
  pdd_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_take            (q_take),
    .q_data            (q_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_forward  (out_left_forward),
    .out_left_duty     (out_left_duty),
    .out_right_forward (out_right_forward),
    .out_right_duty    (out_right_duty)
  );

endmodule

// ----- hdl/pdd_checker.sv -----
// ============================================================================
// pdd_checker: port-level assertions for the PID differential drive
// Watches the result channel over time; bound to the top level below.
// ============================================================================
module pdd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_left_forward,
  input logic [pdd_pkg::SPEED_W-1:0] out_left_duty,
  input logic                        out_right_forward,
  input logic [pdd_pkg::SPEED_W-1:0] out_right_duty
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_forward)
      && $stable(out_left_duty) && $stable(out_right_forward)
      && $stable(out_right_duty))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A zero command is always reported forward
  a_zero_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_duty != '0 || out_left_forward)
      && (out_right_duty != '0 || out_right_forward))
    else $error("zero duty with reverse direction");

  // Motor sums add to twice the base speed, so both cannot reverse
  a_not_both_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_forward || out_right_forward)
    else $error("both motors reversed");

endmodule

bind pid_differential_drive pdd_checker u_pdd_checker (.*);

// ----- tb/tb_pid_differential_drive.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_pid_differential_drive: self-checking bench for the PID steering block
// A clocked driver feeds line positions from a pending queue and predicts
// left/right motor commands at each input transfer. A clocked monitor checks
// every output transfer against the oldest prediction. Registers are written
// between phases, once the pipeline has drained.
// ============================================================================
module tb_pid_differential_drive;
  import pdd_pkg::*;

  localparam int FRAC            = FRAC_BITS_DFLT;
  localparam int SETTLE_CYCLES   = 16;
  localparam int QUIET_LIMIT     = 5000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int PRINT_LIMIT     = 200;

  // Index that maps to no register; writes to it must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    pdd_motor_t left;
    pdd_motor_t right;
  } drive_cmd_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // DUT ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [POS_W-1:0]      in_line_position = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_left_forward;
  logic [SPEED_W-1:0]    out_left_duty;
  logic                  out_right_forward;
  logic [SPEED_W-1:0]    out_right_duty;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the PID state
  logic [GAIN_W-1:0]       ctl_kp;
  logic [GAIN_W-1:0]       ctl_ki;
  logic [GAIN_W-1:0]       ctl_kd;
  logic [SPEED_W-1:0]      ctl_base;
  logic [SPEED_W-1:0]      ctl_max;
  logic [POS_W-1:0]        ctl_target;
  logic [LIMIT_W-1:0]      ctl_limit;
  logic signed [ERR_W-1:0] last_error;
  logic signed [INT_W-1:0] error_sum;

  logic [POS_W-1:0] pending_positions[$];
  drive_cmd_t       expected_cmds[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;

  always #1 clk = ~clk;

  pid_differential_drive i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_line_position  (in_line_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_forward  (out_left_forward),
    .out_left_duty     (out_left_duty),
    .out_right_forward (out_right_forward),
    .out_right_duty    (out_right_duty),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Truncate a Q.FRAC sum toward zero, clamp to +-max_speed, split into dir/duty
  function automatic pdd_motor_t motor_from_fixed(input longint sum);
    longint     whole;
    longint     mag;
    int         bound;
    pdd_motor_t m;
    bound = int'(ctl_max);
    whole = (sum >= 0) ? (sum >>> FRAC) : -((-sum) >>> FRAC);
    if (whole > bound) whole = bound;
    if (whole < -bound) whole = -bound;
    mag = (whole < 0) ? -whole : whole;
    if (mag > 255) mag = 255;
    m.fwd  = (whole >= 0);
    m.duty = mag[SPEED_W-1:0];
    return m;
  endfunction

  // One PID step: advance the state and queue the expected motor commands
  function automatic void predict_drive(input logic [POS_W-1:0] pos);
    int         pos_i;
    int         tgt_i;
    int         err;
    int         integ;
    int         deriv;
    int         lim;
    longint     kp_l;
    longint     ki_l;
    longint     kd_l;
    longint     base_l;
    longint     drive;
    drive_cmd_t cmd;
    pos_i  = int'(pos);
    tgt_i  = int'(ctl_target);
    lim    = int'(ctl_limit);
    kp_l   = longint'(ctl_kp);
    ki_l   = longint'(ctl_ki);
    kd_l   = longint'(ctl_kd);
    base_l = longint'(ctl_base);
    err    = tgt_i - pos_i;
    integ  = int'(error_sum) + err;
    if (integ > lim) integ = lim;
    if (integ < -lim) integ = -lim;
    deriv  = err - int'(last_error);
    drive  = kp_l * err + ki_l * integ + kd_l * deriv;
    error_sum  = INT_W'(integ);
    last_error = ERR_W'(err);
    base_l    = base_l << FRAC;
    cmd.left  = motor_from_fixed(base_l + drive);
    cmd.right = motor_from_fixed(base_l - drive);
    expected_cmds.push_back(cmd);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_LIMIT)
      $display("MISMATCH result %0d %0s: got %0d expected %0d",
               results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 73 : (mode == IDLE_BOTH) ? 36 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 73 : (mode == IDLE_BOTH) ? 36 : 0;
  endtask

  // Register write over the cfg channel; predictor copy follows the transfer
  task automatic write_register(input logic [IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KP_GAIN:         ctl_kp     = data[GAIN_W-1:0];
      REG_KI_GAIN:         ctl_ki     = data[GAIN_W-1:0];
      REG_KD_GAIN:         ctl_kd     = data[GAIN_W-1:0];
      REG_BASE_SPEED:      ctl_base   = data[SPEED_W-1:0];
      REG_MAX_SPEED:       ctl_max    = data[SPEED_W-1:0];
      REG_TARGET_POSITION: ctl_target = data[POS_W-1:0];
      REG_INTEGRAL_LIMIT:  ctl_limit  = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every queued sample is sent and every result has come back;
  // checked mid-cycle so the driver and monitor updates have all landed
  task automatic settle();
    while (pending_positions.size() != 0 || in_valid || expected_cmds.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly useful settings, now and then a full-width word to probe masking
  function automatic logic [CFG_DATA_W-1:0] pick_setting(input cfg_reg_t r);
    int hi;
    case (r)
      REG_KI_GAIN:         hi = 2000;
      REG_BASE_SPEED:      hi = 255;
      REG_MAX_SPEED:       hi = 255;
      REG_TARGET_POSITION: hi = 7000;
      REG_INTEGRAL_LIMIT:  hi = 5000;
      default:             hi = 30000;
    endcase
    if ($urandom_range(3) == 0) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(hi));
  endfunction

  // Mostly tracking runs that wander around the setpoint, plus noise and rails
  task automatic queue_random_positions(input int count);
    int pos;
    int run;
    while (count > 0) begin
      case ($urandom_range(9))
        7, 8: begin
          pending_positions.push_back(POS_W'($urandom_range(8191)));
          count--;
        end
        9: begin
          case ($urandom_range(3))
            0: pending_positions.push_back(POS_W'(0));
            1: pending_positions.push_back(POS_W'(7000));
            2: pending_positions.push_back(POS_W'(8191));
            default: pending_positions.push_back(ctl_target);
          endcase
          count--;
        end
        default: begin
          run = $urandom_range(40, 8);
          pos = int'(ctl_target) + $urandom_range(1000) - 500;
          while (run > 0 && count > 0) begin
            pos = pos + $urandom_range(300) - 150;
            if (pos < 0) pos = 0;
            if (pos > 7000) pos = 7000;
            pending_positions.push_back(POS_W'(pos));
            run--;
            count--;
          end
        end
      endcase
    end
  endtask

  // Driver: predict on each input transfer, then offer the next sample
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_drive(in_line_position);
      if (!in_valid || !in_stall) begin
        if (pending_positions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid         <= 1'b1;
          in_line_position <= pending_positions.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transfer, then pick the next stall
  always @(posedge clk) begin : monitor
    drive_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_cmds.pop_front();
        if (out_left_forward !== want.left.fwd)
          report_mismatch("left_forward", int'(out_left_forward), int'(want.left.fwd));
        if (out_left_duty !== want.left.duty)
          report_mismatch("left_duty", int'(out_left_duty), int'(want.left.duty));
        if (out_right_forward !== want.right.fwd)
          report_mismatch("right_forward", int'(out_right_forward), int'(want.right.fwd));
        if (out_right_duty !== want.right.duty)
          report_mismatch("right_duty", int'(out_right_duty), int'(want.right.duty));
      end
      results_seen++;
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    cfg_reg_t r;
    ctl_kp     = KP_RESET;
    ctl_ki     = KI_RESET;
    ctl_kd     = KD_RESET;
    ctl_base   = BASE_RESET;
    ctl_max    = MAX_RESET;
    ctl_target = TARGET_RESET;
    ctl_limit  = LIMIT_RESET;
    last_error = '0;
    error_sum  = '0;
    set_idling(IDLE_NONE);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: centered, both rails, position past the bar's range
    pending_positions = {13'd3500, 13'd0, 13'd7000, 13'd8191, 13'd8191,
                         13'd0, 13'd1, 13'd3500};
    settle();

    // Integral limit of zero holds the integral at zero
    write_register(REG_KI_GAIN, 24'h010000);
    write_register(REG_INTEGRAL_LIMIT, 24'd0);
    pending_positions = {13'd0, 13'd0, 13'd8191};
    settle();

    // Integral pinned at +limit, then at -limit; negative command direction
    write_register(REG_KP_GAIN, 24'd0);
    write_register(REG_KD_GAIN, 24'd0);
    write_register(REG_BASE_SPEED, 24'd0);
    write_register(REG_MAX_SPEED, 24'd255);
    write_register(REG_INTEGRAL_LIMIT, 24'd100);
    pending_positions = {13'd3400, 13'd3400, 13'd3400, 13'd3600, 13'd3600, 13'd3600};
    settle();

    // Zero command: forward with zero duty
    write_register(REG_KI_GAIN, 24'd0);
    write_register(REG_KP_GAIN, 24'd4260);
    pending_positions = {13'd3500};
    settle();

    // Max speed of zero forces both outputs to forward, zero duty
    write_register(REG_MAX_SPEED, 24'd0);
    write_register(REG_BASE_SPEED, 24'd200);
    pending_positions = {13'd0, 13'd8191};
    settle();

    // Random phases: all-ones, all-zeros, then mixed settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      r = r.first();
      do begin
        case (phase)
          0:       write_register(r, '1);
          1:       write_register(r, '0);
          default: write_register(r, pick_setting(r));
        endcase
        r = r.next();
      end while (r != r.first());
      write_register(REG_UNUSED, CFG_DATA_W'($urandom));
      set_idling(idle_mode_t'(phase % 4));
      queue_random_positions(ITEMS_PER_PHASE);
      settle();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pdd_pkg.sv
hdl/pdd_front.sv
hdl/pdd_queue.sv
hdl/pdd_back.sv
hdl/pid_differential_drive.sv
hdl/pdd_checker.sv
tb/tb_pid_differential_drive.sv
